FILE: src/bmd_pkg.sv
package bmd_pkg;

    localparam int AMP_W   = 24;
    localparam int SQ_W    = 2 * AMP_W;
    localparam int OUT_W   = AMP_W + 1;
    localparam int TIME_W  = 16;
    localparam int MULT_W  = 16;
    localparam int GM_W    = 24;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 2;
    localparam int NBP     = 3;
    localparam int NNBR    = 4;

    localparam int APERTURE_DEF = 2;

    // pipeline depths, counted in registers
    localparam int AMP_LAT  = AMP_W + 2;
    localparam int THR_LAT  = MULT_W + 5;
    localparam int MED_LAT  = 2;
    localparam int LANE_LAT = AMP_W + 2;

    localparam logic [IDX_W-1:0] REG_GLOBAL_MEDIAN = 3'd0;
    localparam logic [IDX_W-1:0] REG_BP_COUNT      = 3'd1;
    localparam logic [IDX_W-1:0] REG_TIME_A        = 3'd2;
    localparam logic [IDX_W-1:0] REG_MULT_A        = 3'd3;
    localparam logic [IDX_W-1:0] REG_TIME_B        = 3'd4;
    localparam logic [IDX_W-1:0] REG_MULT_B        = 3'd5;
    localparam logic [IDX_W-1:0] REG_TIME_C        = 3'd6;
    localparam logic [IDX_W-1:0] REG_MULT_C        = 3'd7;

    localparam logic [MULT_W-1:0] MULT_ONE = 16'd256;

endpackage

FILE: src/bin_median_despike.sv
// channel | dir | beat contents                              | handshake
// in      | in  | bin_re bin_im frame_time nbr_minus/plus_*  | in_valid / in_stall
// out     | out | out_re out_im replaced                     | out_valid / out_stall
// cfg     | in  | cfg_index cfg_data                         | cfg_write
//
// one bin per cycle while the skid register is empty; the pipeline depth, output
// register included, is set by the bit-per-stage root (24) and lane divider (24)
// the breakpoint divider (16 stages) runs alongside the root and is delay matched
// reset loads config defaults, clears valid bits, output and skid flags; no clearing pass
// a beat reaching the end while the output is held goes to a skid register; while it
// is full the whole pipeline freezes and in_stall is that register's full flag
module bin_median_despike
    import bmd_pkg::*;
#(
    parameter int APERTURE = APERTURE_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_write,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [AMP_W-1:0] bin_re,
    input  logic signed [AMP_W-1:0] bin_im,
    input  logic [TIME_W-1:0]       frame_time,
    input  logic [AMP_W-1:0]        nbr_minus_two,
    input  logic [AMP_W-1:0]        nbr_minus_one,
    input  logic [AMP_W-1:0]        nbr_plus_one,
    input  logic [AMP_W-1:0]        nbr_plus_two,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] out_re,
    output logic signed [OUT_W-1:0] out_im,
    output logic                    replaced
);

    localparam int WIN    = 2 * APERTURE + 1;
    localparam int PIPE_N = AMP_LAT + MED_LAT + LANE_LAT + 1;
    localparam int CO_W   = 2 * AMP_W;
    localparam int NB_W   = NNBR * AMP_W;
    localparam int PR_W   = GM_W + MULT_W;

    // configuration
    logic [GM_W-1:0]   gm_reg;
    logic [CNT_W-1:0]  bp_cnt_reg;
    logic [TIME_W-1:0] bp_time_reg [NBP];
    logic [MULT_W-1:0] bp_mult_reg [NBP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gm_reg     <= '0;
            bp_cnt_reg <= CNT_W'(1);
            for (int i = 0; i < NBP; i++)
            begin
                bp_time_reg[i] <= '0;
                bp_mult_reg[i] <= MULT_ONE;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GLOBAL_MEDIAN: gm_reg         <= cfg_data[GM_W-1:0];
                REG_BP_COUNT:      bp_cnt_reg     <= cfg_data[CNT_W-1:0];
                REG_TIME_A:        bp_time_reg[0] <= cfg_data[TIME_W-1:0];
                REG_MULT_A:        bp_mult_reg[0] <= cfg_data[MULT_W-1:0];
                REG_TIME_B:        bp_time_reg[1] <= cfg_data[TIME_W-1:0];
                REG_MULT_B:        bp_mult_reg[1] <= cfg_data[MULT_W-1:0];
                REG_TIME_C:        bp_time_reg[2] <= cfg_data[TIME_W-1:0];
                REG_MULT_C:        bp_mult_reg[2] <= cfg_data[MULT_W-1:0];
                default:           ;
            endcase
        end
    end

    // pipeline control
    logic              en;
    logic              skid_vld_reg;
    logic              out_vld_reg;
    logic [PIPE_N-1:0] v_reg;

    assign en       = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[PIPE_N-2:0], in_valid};
        end
    end

    // input registers
    logic signed [AMP_W-1:0] i_re_reg;
    logic signed [AMP_W-1:0] i_im_reg;
    logic [TIME_W-1:0]       i_t_reg;
    logic [NB_W-1:0]         i_nbr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_re_reg  <= bin_re;
            i_im_reg  <= bin_im;
            i_t_reg   <= frame_time;
            i_nbr_reg <= {nbr_plus_two, nbr_plus_one, nbr_minus_one, nbr_minus_two};
        end
    end

    // amplitude
    logic [AMP_W-1:0] amp;

    bmd_isqrt u_isqrt (
        .clk (clk),
        .en  (en),
        .re  (i_re_reg),
        .im  (i_im_reg),
        .amp (amp)
    );

    // breakpoint select; a direct multiplier goes through the divider as m0 + 0
    logic [CNT_W-1:0]  bp_n;
    logic [CNT_W-1:0]  bp_idx;
    logic              bp_hit;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
    logic [MULT_W-1:0] m0;
    logic [MULT_W-1:0] m1;
    logic [MULT_W-1:0] p1_m0_next;
    logic              p1_neg_next;
    logic [MULT_W-1:0] p1_dm_next;
    logic [TIME_W-1:0] p1_dt_next;
    logic [TIME_W-1:0] p1_den_next;

    always_comb
    begin
        bp_n   = (bp_cnt_reg == '0) ? CNT_W'(1) : bp_cnt_reg;
        bp_idx = bp_n;
        bp_hit = 1'b0;
        for (int i = 0; i < NBP; i++)
        begin
            if (!bp_hit && (CNT_W'(i) < bp_n) && (bp_time_reg[i] >= i_t_reg))
            begin
                bp_idx = CNT_W'(i);
                bp_hit = 1'b1;
            end
        end
        t0 = bp_time_reg[CNT_W'(bp_idx - CNT_W'(1))];
        t1 = bp_time_reg[bp_idx];
        m0 = bp_mult_reg[CNT_W'(bp_idx - CNT_W'(1))];
        m1 = bp_mult_reg[bp_idx];

        p1_neg_next = 1'b0;
        p1_dm_next  = '0;
        p1_dt_next  = '0;
        p1_den_next = TIME_W'(1);
        if (bp_idx == '0)
        begin
            p1_m0_next = bp_mult_reg[0];
        end
        else if (bp_idx == bp_n)
        begin
            p1_m0_next = bp_mult_reg[CNT_W'(bp_n - CNT_W'(1))];
        end
        else
        begin
            p1_m0_next  = m0;
            p1_neg_next = m1 < m0;
            p1_dm_next  = (m1 < m0) ? (m0 - m1) : (m1 - m0);
            p1_dt_next  = i_t_reg - t0;
            p1_den_next = t1 - t0;
        end
    end

    logic [MULT_W-1:0]        p1_m0_reg;
    logic                     p1_neg_reg;
    logic [MULT_W-1:0]        p1_dm_reg;
    logic [TIME_W-1:0]        p1_dt_reg;
    logic [TIME_W-1:0]        p1_den_reg;
    logic [TIME_W+MULT_W-1:0] p2_num_reg;
    logic [TIME_W-1:0]        p2_den_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_m0_reg  <= p1_m0_next;
            p1_neg_reg <= p1_neg_next;
            p1_dm_reg  <= p1_dm_next;
            p1_dt_reg  <= p1_dt_next;
            p1_den_reg <= p1_den_next;
            p2_num_reg <= p1_dt_reg * p1_dm_reg;
            p2_den_reg <= p1_den_reg;
        end
    end

    logic [MULT_W-1:0] interp_q;
    logic [MULT_W-1:0] side_m0;
    logic              side_neg;

    bmd_div #(
        .DW (TIME_W),
        .QW (MULT_W)
    ) u_interp_div (
        .clk (clk),
        .en  (en),
        .num (p2_num_reg),
        .den (p2_den_reg),
        .quo (interp_q)
    );

    bmd_pipe #(
        .W (MULT_W + 1),
        .N (MULT_W + 1)
    ) u_side (
        .clk (clk),
        .en  (en),
        .d   ({p1_m0_reg, p1_neg_reg}),
        .q   ({side_m0, side_neg})
    );

    logic [MULT_W-1:0] mult_reg;
    logic [PR_W-1:0]   thr_prod_reg;
    logic [AMP_W-1:0]  thr_reg;
    logic [AMP_W-1:0]  thr_d;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mult_reg     <= side_neg ? (side_m0 - interp_q) : (side_m0 + interp_q);
            thr_prod_reg <= gm_reg * mult_reg;
            thr_reg      <= (|thr_prod_reg[PR_W-1:AMP_W+8]) ? '1
                                                            : thr_prod_reg[AMP_W+7:8];
        end
    end

    bmd_pipe #(
        .W (AMP_W),
        .N (AMP_LAT - THR_LAT)
    ) u_thr_dly (
        .clk (clk),
        .en  (en),
        .d   (thr_reg),
        .q   (thr_d)
    );

    // window median
    logic [NB_W-1:0]  nbr_d;
    logic [AMP_W-1:0] win [WIN];
    logic [AMP_W-1:0] med;

    bmd_pipe #(
        .W (NB_W),
        .N (AMP_LAT)
    ) u_nbr_dly (
        .clk (clk),
        .en  (en),
        .d   (i_nbr_reg),
        .q   (nbr_d)
    );

    assign win[0] = amp;
    for (genvar d = 1; d <= APERTURE; d++)
    begin : g_win
        if (d == 1)
        begin : g_one
            assign win[2*d-1] = nbr_d[2*AMP_W-1:AMP_W];
            assign win[2*d]   = nbr_d[3*AMP_W-1:2*AMP_W];
        end
        else if (d == 2)
        begin : g_two
            assign win[2*d-1] = nbr_d[AMP_W-1:0];
            assign win[2*d]   = nbr_d[4*AMP_W-1:3*AMP_W];
        end
        else
        begin : g_far
            // traces this far out are not carried
            assign win[2*d-1] = '0;
            assign win[2*d]   = '0;
        end
    end

    bmd_median #(
        .WIN (WIN)
    ) u_median (
        .clk  (clk),
        .en   (en),
        .vals (win),
        .med  (med)
    );

    logic rep_d;

    bmd_pipe #(
        .W (1),
        .N (MED_LAT + LANE_LAT)
    ) u_rep_dly (
        .clk (clk),
        .en  (en),
        .d   (amp > thr_d),
        .q   (rep_d)
    );

    logic [AMP_W-1:0]        amp_d;
    logic signed [AMP_W-1:0] l_re;
    logic signed [AMP_W-1:0] l_im;
    logic signed [AMP_W-1:0] o_re;
    logic signed [AMP_W-1:0] o_im;

    bmd_pipe #(
        .W (AMP_W),
        .N (MED_LAT)
    ) u_amp_dly (
        .clk (clk),
        .en  (en),
        .d   (amp),
        .q   (amp_d)
    );

    bmd_pipe #(
        .W (CO_W),
        .N (AMP_LAT + MED_LAT)
    ) u_comp_dly (
        .clk (clk),
        .en  (en),
        .d   ({i_re_reg, i_im_reg}),
        .q   ({l_re, l_im})
    );

    bmd_pipe #(
        .W (CO_W),
        .N (LANE_LAT)
    ) u_orig_dly (
        .clk (clk),
        .en  (en),
        .d   ({l_re, l_im}),
        .q   ({o_re, o_im})
    );

    // one lane per component
    logic signed [OUT_W-1:0] lane_re;
    logic signed [OUT_W-1:0] lane_im;

    bmd_lane u_lane_re (
        .clk  (clk),
        .en   (en),
        .med  (med),
        .comp (l_re),
        .amp  (amp_d),
        .res  (lane_re)
    );

    bmd_lane u_lane_im (
        .clk  (clk),
        .en   (en),
        .med  (med),
        .comp (l_im),
        .amp  (amp_d),
        .res  (lane_im)
    );

    // merge
    logic signed [OUT_W-1:0] m_re;
    logic signed [OUT_W-1:0] m_im;
    logic                    pipe_out;

    assign m_re     = rep_d ? lane_re : {o_re[AMP_W-1], o_re};
    assign m_im     = rep_d ? lane_im : {o_im[AMP_W-1], o_im};
    assign pipe_out = v_reg[PIPE_N-1] && en;

    // output register and skid
    logic signed [OUT_W-1:0] out_re_reg;
    logic signed [OUT_W-1:0] out_im_reg;
    logic                    out_rep_reg;
    logic signed [OUT_W-1:0] skid_re_reg;
    logic signed [OUT_W-1:0] skid_im_reg;
    logic                    skid_rep_reg;
    logic                    taken;

    assign taken = out_vld_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (taken)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (pipe_out)
        begin
            if (!out_vld_reg || taken)
            begin
                out_vld_reg <= 1'b1;
            end
            else
            begin
                skid_vld_reg <= 1'b1;
            end
        end
        else if (taken)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (taken)
            begin
                out_re_reg  <= skid_re_reg;
                out_im_reg  <= skid_im_reg;
                out_rep_reg <= skid_rep_reg;
            end
        end
        else if (pipe_out)
        begin
            if (!out_vld_reg || taken)
            begin
                out_re_reg  <= m_re;
                out_im_reg  <= m_im;
                out_rep_reg <= rep_d;
            end
            else
            begin
                skid_re_reg  <= m_re;
                skid_im_reg  <= m_im;
                skid_rep_reg <= rep_d;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign replaced  = out_rep_reg;

endmodule

FILE: src/bmd_pipe.sv
module bmd_pipe
    import bmd_pkg::*;
#(
    parameter int W = 1,
    parameter int N = 1
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] stage_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= d;
            for (int i = 1; i < N; i++)
            begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign q = stage_reg[N-1];

endmodule

FILE: src/bmd_div.sv
module bmd_div
    import bmd_pkg::*;
#(
    parameter int DW = 16,
    parameter int QW = 16
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [DW+QW-1:0]  num,
    input  logic [DW-1:0]     den,
    output logic [QW-1:0]     quo
);

    // restoring divider, one quotient bit per stage; needs num < den * 2^QW
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] sh_reg  [QW];
    logic [DW-1:0] den_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] sh_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign rem_in = num[DW+QW-1:QW];
            assign sh_in  = num[QW-1:0];
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign sh_in  = sh_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        assign trial = {rem_in, sh_in[QW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                sh_reg[i]  <= {sh_in[QW-2:0], ge};
                den_reg[i] <= den_in;
            end
        end
    end

    assign quo = sh_reg[QW-1];

endmodule

FILE: src/bmd_isqrt.sv
module bmd_isqrt
    import bmd_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [AMP_W-1:0] re,
    input  logic signed [AMP_W-1:0] im,
    output logic [AMP_W-1:0]        amp
);

    localparam int RW = AMP_W + 2;

    logic [AMP_W-1:0] ure;
    logic [AMP_W-1:0] uim;
    logic [SQ_W-1:0]  sq_re_reg;
    logic [SQ_W-1:0]  sq_im_reg;
    logic [SQ_W-1:0]  sum_reg;

    logic [RW-1:0]    rem_reg  [AMP_W];
    logic [AMP_W-1:0] root_reg [AMP_W];
    logic [SQ_W-1:0]  v_reg    [AMP_W];

    assign ure = re[AMP_W-1] ? AMP_W'(-re) : AMP_W'(re);
    assign uim = im[AMP_W-1] ? AMP_W'(-im) : AMP_W'(im);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_re_reg <= ure * ure;
            sq_im_reg <= uim * uim;
            sum_reg   <= sq_re_reg + sq_im_reg;
        end
    end

    // digit-by-digit root, one result bit per stage
    for (genvar i = 0; i < AMP_W; i++)
    begin : g_root
        logic [RW-1:0]    rem_in;
        logic [AMP_W-1:0] root_in;
        logic [SQ_W-1:0]  v_in;
        logic [RW+1:0]    cur;
        logic [RW+1:0]    trial;
        logic [RW+1:0]    diff;
        logic             ge;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = sum_reg;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign v_in    = v_reg[i-1];
        end

        assign cur   = {rem_in, v_in[SQ_W-1:SQ_W-2]};
        assign trial = (RW+2)'({root_in, 2'b01});
        assign diff  = cur - trial;
        assign ge    = cur >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= ge ? diff[RW-1:0] : cur[RW-1:0];
                root_reg[i] <= {root_in[AMP_W-2:0], ge};
                v_reg[i]    <= {v_in[SQ_W-3:0], 2'b00};
            end
        end
    end

    assign amp = root_reg[AMP_W-1];

endmodule

FILE: src/bmd_median.sv
module bmd_median
    import bmd_pkg::*;
#(
    parameter int WIN = 5
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [AMP_W-1:0] vals [WIN],
    output logic [AMP_W-1:0] med
);

    localparam int RK_W = $clog2(WIN);
    localparam int MID  = WIN / 2;

    logic [WIN-1:0]   below_reg [WIN];
    logic [AMP_W-1:0] val_reg   [WIN];
    logic [AMP_W-1:0] med_reg;
    logic [AMP_W-1:0] med_next;

    // ties broken by position so the ranks form a permutation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                val_reg[i] <= vals[i];
                for (int j = 0; j < WIN; j++)
                begin
                    below_reg[i][j] <= (vals[j] < vals[i]) ||
                                       ((vals[j] == vals[i]) && (j < i));
                end
            end
            med_reg <= med_next;
        end
    end

    always_comb
    begin
        logic [RK_W-1:0] rank;
        med_next = '0;
        for (int i = 0; i < WIN; i++)
        begin
            rank = '0;
            for (int j = 0; j < WIN; j++)
            begin
                rank = rank + RK_W'(below_reg[i][j]);
            end
            if (rank == RK_W'(MID))
            begin
                med_next = med_next | val_reg[i];
            end
        end
    end

    assign med = med_reg;

endmodule

FILE: src/bmd_lane.sv
module bmd_lane
    import bmd_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [AMP_W-1:0]        med,
    input  logic signed [AMP_W-1:0] comp,
    input  logic [AMP_W-1:0]        amp,
    output logic signed [OUT_W-1:0] res
);

    logic [AMP_W-1:0]        ucomp;
    logic [SQ_W-1:0]         prod_reg;
    logic [AMP_W-1:0]        amp_reg;
    logic                    neg_reg;
    logic                    neg_d;
    logic [AMP_W-1:0]        quo;
    logic signed [OUT_W-1:0] res_reg;

    assign ucomp = comp[AMP_W-1] ? AMP_W'(-comp) : AMP_W'(comp);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= med * ucomp;
            amp_reg  <= amp;
            neg_reg  <= comp[AMP_W-1];
        end
    end

    // |comp| <= amp, so the quotient never exceeds the median unless amp is zero
    bmd_div #(
        .DW (AMP_W),
        .QW (AMP_W)
    ) u_div (
        .clk (clk),
        .en  (en),
        .num (prod_reg),
        .den (amp_reg),
        .quo (quo)
    );

    bmd_pipe #(
        .W (1),
        .N (AMP_W)
    ) u_sign (
        .clk (clk),
        .en  (en),
        .d   (neg_reg),
        .q   (neg_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= neg_d ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        end
    end

    assign res = res_reg;

endmodule
